[rtl/core/ohsa_pkg.sv]
package ohsa_pkg;

  localparam int MAX_HANDLES = 1024;
  localparam int HANDLE_W    = 10;
  localparam int COUNT_W     = 11;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int WADDR_W     = HANDLE_W - BIT_W;
  localparam int NUM_WORDS   = MAX_HANDLES / WORD_W;

  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] REWIND_MIN = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] LEN_RESET  = COUNT_W'(1);

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_EXISTS = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic eval;
    logic append;
    logic finish;
  } ohsa_cmd_t;

  typedef struct packed {
    logic needs_read;
    logic is_alloc;
    logic found;
    logic more;
    logic out_free;
  } ohsa_stat_t;

endpackage

[rtl/core/ohsa_ctrl.sv]
module ohsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ohsa_pkg::ohsa_stat_t stat,
  output ohsa_pkg::ohsa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.start = 1'b1;
        priority if (stat.needs_read) begin
          state_next = S_EVAL;
        end else if (stat.is_alloc) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        // An allocate that finds nothing in this word moves on to the next one, or appends a slot when no word is left.
        priority if (!stat.is_alloc || stat.found) begin
          state_next = S_FINISH;
        end else if (stat.more) begin
          state_next = S_EVAL;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ohsa_datapath.sv]
module ohsa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  ohsa_pkg::ohsa_cmd_t                 cmd,
  output ohsa_pkg::ohsa_stat_t                stat,
  input  logic [ohsa_pkg::OP_W-1:0]           in_op,
  input  logic [ohsa_pkg::HANDLE_W-1:0]       in_handle,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ohsa_pkg::OUT_DATA_W-1:0]     out_data
);

  logic [ohsa_pkg::WORD_W-1:0] mem [ohsa_pkg::NUM_WORDS];
  logic [ohsa_pkg::NUM_WORDS-1:0] row_valid;
  logic [ohsa_pkg::WORD_W-1:0]    rd_data;

  logic [ohsa_pkg::OP_W-1:0]     op_q;
  logic [ohsa_pkg::HANDLE_W-1:0] handle_q;
  logic [ohsa_pkg::COUNT_W-1:0]  ptr;
  logic [ohsa_pkg::COUNT_W-1:0]  len;
  logic [ohsa_pkg::COUNT_W-1:0]  cnt;
  logic [ohsa_pkg::HANDLE_W-1:0] res_handle;
  logic [ohsa_pkg::ST_W-1:0]     res_status;

  logic [ohsa_pkg::HANDLE_W-1:0] out_handle;
  logic [ohsa_pkg::ST_W-1:0]     out_status;
  logic [ohsa_pkg::COUNT_W-1:0]  out_count;

  logic                           is_alloc;
  logic                           handle_in_len;
  logic                           hit;
  logic                           can_append;
  logic [ohsa_pkg::WORD_W-1:0]    free_mask;
  logic                           found;
  logic [ohsa_pkg::BIT_W-1:0]     found_idx;
  logic [ohsa_pkg::WADDR_W:0]     word_inc;
  logic [ohsa_pkg::COUNT_W-1:0]   next_start;
  logic                           more;
  logic [ohsa_pkg::HANDLE_W-1:0]  found_handle;
  logic [ohsa_pkg::HANDLE_W-1:0]  app_handle;
  logic                           app_pow2;
  logic [ohsa_pkg::COUNT_W-1:0]   half_len;
  logic [ohsa_pkg::COUNT_W-1:0]   rewind_ptr;

  logic                           rd_en;
  logic [ohsa_pkg::WADDR_W-1:0]   rd_addr;
  logic                           wr_en;
  logic [ohsa_pkg::WADDR_W-1:0]   wr_addr;
  logic [ohsa_pkg::BIT_W-1:0]     wr_bit;
  logic                           wr_val;

  assign is_alloc      = (op_q == ohsa_pkg::OP_ALLOC);
  assign handle_in_len = ({1'b0, handle_q} < len);
  assign hit           = rd_data[handle_q[ohsa_pkg::BIT_W-1:0]];
  assign can_append    = (len < ohsa_pkg::COUNT_W'(ohsa_pkg::MAX_HANDLES));

  // Free slots in the current word at or above the pointer and below the length.
  always_comb begin
    logic [ohsa_pkg::HANDLE_W-1:0] g;
    logic [ohsa_pkg::BIT_W-1:0]    b;
    for (int i = 0; i < ohsa_pkg::WORD_W; i++) begin
      b = ohsa_pkg::BIT_W'(i);
      g = {ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W], b};
      free_mask[i] = !rd_data[i] && (b >= ptr[ohsa_pkg::BIT_W-1:0]) && ({1'b0, g} < len);
    end
  end

  always_comb begin
    found_idx = '0;
    for (int i = ohsa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        found_idx = ohsa_pkg::BIT_W'(i);
      end
    end
  end

  assign found        = |free_mask;
  assign found_handle = {ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W], found_idx};
  assign word_inc     = {1'b0, ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W]} + 1'b1;
  assign next_start   = {word_inc, {ohsa_pkg::BIT_W{1'b0}}};
  assign more         = (next_start < len);

  // The pointer equals the length whenever a slot is appended.
  assign app_handle = len[ohsa_pkg::HANDLE_W-1:0];
  assign app_pow2   = ((app_handle & (app_handle - 1'b1)) == '0);
  assign half_len   = len >> 1;
  assign rewind_ptr = (half_len > ohsa_pkg::REWIND_MIN) ? half_len : ohsa_pkg::REWIND_MIN;

  assign stat.needs_read = is_alloc ? (ptr < len)
                         : ((op_q == ohsa_pkg::OP_FREE || op_q == ohsa_pkg::OP_EXISTS)
                            && handle_in_len);
  assign stat.is_alloc   = is_alloc;
  assign stat.found      = found;
  assign stat.more       = more;
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
    if (cmd.start) begin
      rd_en   = 1'b1;
      rd_addr = is_alloc ? ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W]
                         : handle_q[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
    end else if (cmd.eval && is_alloc && !found && more) begin
      rd_en   = 1'b1;
      rd_addr = next_start[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
    wr_bit  = found_idx;
    wr_val  = 1'b1;
    if (cmd.eval && is_alloc && found) begin
      wr_en = 1'b1;
    end else if (cmd.eval && op_q == ohsa_pkg::OP_FREE && hit) begin
      wr_en   = 1'b1;
      wr_addr = handle_q[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
      wr_bit  = handle_q[ohsa_pkg::BIT_W-1:0];
      wr_val  = 1'b0;
    end else if (cmd.append && can_append) begin
      wr_en   = 1'b1;
      wr_addr = len[ohsa_pkg::HANDLE_W-1:ohsa_pkg::BIT_W];
      wr_bit  = len[ohsa_pkg::BIT_W-1:0];
    end
  end

  // A row that was never written reads as all free; its first write fills the whole row.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_valid[wr_addr]) begin
        mem[wr_addr][wr_bit] <= wr_val;
      end else begin
        mem[wr_addr] <= {{(ohsa_pkg::WORD_W-1){1'b0}}, wr_val} << wr_bit;
      end
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= ohsa_pkg::LEN_RESET;
      len <= ohsa_pkg::LEN_RESET;
      cnt <= '0;
    end else begin
      if (cmd.eval) begin
        if (is_alloc) begin
          if (found) begin
            ptr <= {1'b0, found_handle};
            cnt <= cnt + 1'b1;
          end else if (more) begin
            ptr <= next_start;
          end else begin
            ptr <= len;
          end
        end else if (op_q == ohsa_pkg::OP_FREE && hit) begin
          cnt <= cnt - 1'b1;
        end
      end
      if (cmd.append && can_append) begin
        len <= len + 1'b1;
        cnt <= cnt + 1'b1;
        if (app_pow2) begin
          ptr <= rewind_ptr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= in_op;
      handle_q   <= in_handle;
      res_handle <= in_handle;
      res_status <= ohsa_pkg::ST_NOT_FOUND;
    end
    if (cmd.eval) begin
      if (is_alloc && found) begin
        res_handle <= found_handle;
        res_status <= ohsa_pkg::ST_OK;
      end else if (!is_alloc && hit) begin
        res_status <= ohsa_pkg::ST_OK;
      end
    end
    if (cmd.append) begin
      if (can_append) begin
        res_handle <= app_handle;
        res_status <= ohsa_pkg::ST_OK;
      end else begin
        res_handle <= '0;
        res_status <= ohsa_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_handle <= res_handle;
      out_status <= res_status;
      out_count  <= cnt;
    end
  end

  assign out_data = {1'b0, out_count, out_status, out_handle};

endmodule

[rtl/core/object_handle_slot_allocator.sv]
// Channel | Dir | Bits                                | Meaning
// s_*     | in  | tdata[1:0] op, tdata[11:2] handle   | request
// m_*     | out | tdata[9:0] handle, [11:10] status,  | one result per request
//         |     | tdata[22:12] live count             |
// A free or exists request steps through look, eval and finish; look goes straight to
// finish when the handle lies beyond the table length, and for an unused op code.
// An allocate steps through look, then eval for each 32-slot word of the occupied map
// scanned from the pointer (up to 32), then append when the scan finds no free slot, then finish.
// The map is a 32 x 32 memory with one registered read port; its scan sets the rate.
// Reset (rst, synchronous) clears the map through per-row valid bits, so there is no
// clearing pass. A new request is taken while a result waits in the output register,
// but its own result holds the controller until that register is free.
module object_handle_slot_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ohsa_pkg::IN_DATA_W-1:0]    s_tdata,  // op, handle
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ohsa_pkg::OUT_DATA_W-1:0]   m_tdata   // result_handle, status, live_count
);

  ohsa_pkg::ohsa_cmd_t  cmd;
  ohsa_pkg::ohsa_stat_t stat;

  ohsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ohsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (s_tdata[ohsa_pkg::OP_W-1:0]),
    .in_handle (s_tdata[ohsa_pkg::OP_W+ohsa_pkg::HANDLE_W-1:ohsa_pkg::OP_W]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in progress");

  // Freed slots below the pointer stay unused once the table is full, so the
  // live count can be anything up to the last handle.
  a_full_means_full : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11:10] == ohsa_pkg::ST_FULL)
      |-> (m_tdata[9:0] == '0
           && m_tdata[22:12] <= ohsa_pkg::COUNT_W'(ohsa_pkg::MAX_HANDLES - 1)))
    else $error("full status with a nonzero handle or an impossible live count");

  a_slot_zero_unused : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11:10] == ohsa_pkg::ST_OK) |-> (m_tdata[9:0] != '0))
    else $error("slot zero reported live");

endmodule

[verif/object_handle_slot_allocator_tb.sv]
module object_handle_slot_allocator_tb;
  import ohsa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 17;
  localparam int DRAIN_TAIL = 40;

  typedef struct packed {
    logic [HANDLE_W-1:0] slot;
    logic [ST_W-1:0]     status;
    logic [COUNT_W-1:0]  live_count;
  } handle_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // op [1:0], handle [11:2]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // result_handle [9:0], status [11:10], live_count [22:12]

  // Shadow of the allocator state.
  bit slot_busy [MAX_HANDLES];
  int table_len = 1;
  int scan_ptr = 1;
  int live_total = 0;

  handle_result_t pending_results[$];
  logic [ST_W-1:0] last_status;
  bit no_idle = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  object_handle_slot_allocator uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("object_handle_slot_allocator verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic handle_result_t predict_request(logic [OP_W-1:0] op,
                                                     logic [HANDLE_W-1:0] h);
    handle_result_t r;
    int fresh;
    int half;
    r.slot = h;
    r.status = ST_NOT_FOUND;
    if (op == OP_ALLOC) begin
      while (scan_ptr < table_len && scan_ptr < MAX_HANDLES && slot_busy[scan_ptr])
        scan_ptr++;
      if (scan_ptr < table_len) begin
        r.slot = HANDLE_W'(scan_ptr);
        slot_busy[scan_ptr] = 1'b1;
        live_total++;
        r.status = ST_OK;
      end else if (table_len < MAX_HANDLES) begin
        fresh = table_len;
        r.slot = HANDLE_W'(fresh);
        slot_busy[fresh] = 1'b1;
        table_len++;
        live_total++;
        r.status = ST_OK;
        // Appending a power-of-two handle pulls the pointer back to reuse holes.
        if ((fresh & (fresh - 1)) == 0) begin
          half = scan_ptr / 2;
          scan_ptr = (half > 2) ? half : 2;
        end
      end else begin
        r.slot = '0;
        r.status = ST_FULL;
      end
    end else if (op == OP_FREE) begin
      if (h < table_len && slot_busy[h]) begin
        slot_busy[h] = 1'b0;
        live_total--;
        r.status = ST_OK;
      end
    end else if (op == OP_EXISTS) begin
      if (h < table_len && slot_busy[h])
        r.status = ST_OK;
    end
    r.live_count = COUNT_W'(live_total);
    return r;
  endfunction

  // Entered and left just after a falling edge; tvalid stays high on exit.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
    int gap;
    handle_result_t r;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT)
      gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - OP_W - HANDLE_W){1'b0}}, h, op};
    do @(posedge clk); while (!s_tready);
    r = predict_request(op, h);
    last_status = r.status;
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    handle_result_t want;
    handle_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.slot = m_tdata[HANDLE_W-1:0];
      got.status = m_tdata[HANDLE_W +: ST_W];
      got.live_count = m_tdata[HANDLE_W + ST_W +: COUNT_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result: handle %0d status %0d live_count %0d",
               got.slot, got.status, got.live_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot) begin
          $error("result_handle: expected %0d, got %0d", want.slot, got.slot);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          mismatches++;
        end
      end
    end
  end

  // Requests against a table that holds nothing yet.
  task automatic test_empty_table();
    send_request(OP_FREE, 10'd0);
    send_request(OP_EXISTS, 10'd0);
    send_request(OP_FREE, 10'd1023);
    send_request(OP_EXISTS, 10'd1);
    send_request(OP_UNUSED, 10'd1023);
    send_request(OP_UNUSED, 10'd0);
  endtask

  // Growth, rewinds, frees below the pointer and out-of-range handles.
  task automatic test_basic_alloc_free();
    repeat (5) send_request(OP_ALLOC, 10'h3FF);
    send_request(OP_FREE, 10'd2);
    send_request(OP_EXISTS, 10'd2);
    send_request(OP_EXISTS, 10'd3);
    send_request(OP_FREE, 10'd2);
    send_request(OP_ALLOC, 10'd0);
    send_request(OP_ALLOC, 10'd0);
    send_request(OP_EXISTS, 10'd0);
    send_request(OP_FREE, 10'd1000);
    send_request(OP_EXISTS, 10'd1023);
    send_request(OP_UNUSED, 10'd3);
    wait_all_results();
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(99) < 70)
      return HANDLE_W'($urandom_range(table_len - 1, 0));
    return HANDLE_W'($urandom_range(MAX_HANDLES - 1, 0));
  endfunction

  task automatic test_random_mix(input int count, input int alloc_pct);
    int pick;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 3 + 150);
      if (i == count / 2)
        wait_all_results();
      pick = $urandom_range(99);
      if (pick < alloc_pct)
        send_request(OP_ALLOC, HANDLE_W'($urandom_range(MAX_HANDLES - 1, 0)));
      else if (pick < alloc_pct + (100 - alloc_pct) / 2)
        send_request(OP_FREE, pick_handle());
      else if (pick < 95)
        send_request(OP_EXISTS, pick_handle());
      else
        send_request(OP_UNUSED, pick_handle());
    end
    no_idle = 1'b0;
    wait_all_results();
  endtask

  // Allocate until the table reports full, then poke at it while full.
  task automatic test_fill_to_full();
    do
      send_request(OP_ALLOC, HANDLE_W'($urandom_range(MAX_HANDLES - 1, 0)));
    while (last_status != ST_FULL);
    repeat (5) send_request(OP_ALLOC, 10'h3FF);
    send_request(OP_EXISTS, 10'd1023);
    send_request(OP_FREE, 10'd1023);
    send_request(OP_EXISTS, 10'd1023);
    repeat (20) send_request(OP_FREE, HANDLE_W'($urandom_range(MAX_HANDLES - 1, 1)));
    repeat (10) send_request(OP_ALLOC, 10'd0);
    send_request(OP_FREE, 10'd0);
    wait_all_results();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_basic_alloc_free();
    test_random_mix(500, 60);
    test_random_mix(300, 45);
    test_random_mix(200, 75);
    test_fill_to_full();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("object_handle_slot_allocator verification clean");
    end else begin
      $display("object_handle_slot_allocator verification failed");
    end
    $finish;
  end

endmodule
